/* src/rtks_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Row top-k select package
// Shared constants, the controller/datapath command and status structs, and
// the float32 ordering key.
// ----------------------------------------------------------------------------
package rtks_pkg;

  localparam int KMaxDefault   = 16;
  localparam int RowMaxDefault = 65536;

  localparam int ValueW = 32;
  localparam int IndexW = 16;
  localparam int KCfgW  = 5;

  // Configuration register indexes.
  localparam logic [KCfgW-1:0] RegKCount     = 5'd0;
  localparam logic [KCfgW-1:0] RegPickLargest = 5'd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic insert;     // insert the presented element into the kept list
    logic clear_row;  // start a new row
    logic load_out;   // load the output register from the read slot
    logic read_next;  // advance the read slot
  } rtks_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_busy;   // output register holds a result not yet taken
    logic read_last;  // current read slot is the final one to emit
  } rtks_stat_t;

  // Monotone 33-bit key: NaN above all numbers, -0 folded onto +0.
  function automatic logic [32:0] order_key(input logic [31:0] bits);
    logic [30:0] mag;
    logic [31:0] b;
    logic [32:0] key;
    mag = bits[30:0];
    b   = bits;
    if (mag == 31'd0) begin
      b = 32'd0;
    end
    if (mag > 31'h7F80_0000) begin
      key = {1'b1, 32'd0};
    end else if (b[31]) begin
      key = {1'b0, ~b};
    end else begin
      key = {1'b0, b | 32'h8000_0000};
    end
    return key;
  endfunction

endpackage : rtks_pkg
`default_nettype wire

/* src/rtks_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Row top-k select datapath
// Kept list as an insertion chain of registers, position counter, read slot
// and output register.
// ----------------------------------------------------------------------------
module rtks_datapath #(
  parameter int K_MAX   = rtks_pkg::KMaxDefault,
  parameter int ROW_MAX = rtks_pkg::RowMaxDefault
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire logic [31:0]         elem_value,
  input  wire logic [4:0]          k_count,
  input  wire logic                pick_largest,
  input  wire logic                out_take,
  input  wire rtks_pkg::rtks_cmd_t cmd,
  output rtks_pkg::rtks_stat_t     stat,
  output logic                     out_valid,
  output logic [31:0]              best_value,
  output logic [15:0]              best_index,
  output logic                     last_of_row
);
  import rtks_pkg::*;

  localparam int CntW = $clog2(K_MAX + 1);
  localparam int SlotW = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam int PosW = (ROW_MAX > 2) ? $clog2(ROW_MAX) : 1;

  logic [31:0]     kept_values  [K_MAX];
  logic [15:0]     kept_indices [K_MAX];
  logic [CntW-1:0] kept_count;
  logic [PosW-1:0] position_counter;
  logic [SlotW-1:0] read_slot;

  logic [K_MAX-1:0] beat;
  logic [K_MAX-1:0] place;
  logic [32:0]      new_key;
  logic [CntW-1:0]  k_eff;
  logic [CntW-1:0]  n_emit;
  logic [15:0]      pos_index;

  // Compare the new element against every kept entry at once.
  always_comb begin
    new_key = order_key(elem_value);
    for (int i = 0; i < K_MAX; i++) begin
      beat[i] = (CntW'(i) < kept_count) &&
                (pick_largest ? (new_key > order_key(kept_values[i]))
                              : (new_key < order_key(kept_values[i])));
    end
    // An entry takes the new element when it is the first beaten or the first
    // free slot; entries after that point shift down.
    for (int i = 0; i < K_MAX; i++) begin
      if (i == 0) begin
        place[i] = beat[i] || (kept_count == '0);
      end else begin
        place[i] = place[i-1] || beat[i] ||
                   (CntW'(i) == kept_count);
      end
    end
  end

  // Effective k and the number of pairs to emit.
  always_comb begin
    if (k_count == 5'd0) begin
      k_eff = CntW'(1);
    end else if (32'(k_count) > K_MAX) begin
      k_eff = CntW'(K_MAX);
    end else begin
      k_eff = CntW'(k_count);
    end
    n_emit = (kept_count < k_eff) ? kept_count : k_eff;
  end

  // Keep a narrow position value as the 16-bit index.
  always_comb begin
    pos_index = 16'(position_counter);
  end

  // Insertion chain.
  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      for (int i = 0; i < K_MAX; i++) begin
        if (place[i]) begin
          if (i == 0 || !place[(i > 0) ? i-1 : 0]) begin
            kept_values[i]  <= elem_value;
            kept_indices[i] <= pos_index;
          end else begin
            kept_values[i]  <= kept_values[(i > 0) ? i-1 : 0];
            kept_indices[i] <= kept_indices[(i > 0) ? i-1 : 0];
          end
        end
      end
    end
  end

  // Fill count and position counter.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_row) begin
      kept_count       <= '0;
      position_counter <= '0;
    end else if (cmd.insert) begin
      if (kept_count < CntW'(K_MAX) && (|place)) begin
        kept_count <= kept_count + CntW'(1);
      end
      if (32'(position_counter) == ROW_MAX - 1) begin
        position_counter <= '0;
      end else begin
        position_counter <= position_counter + PosW'(1);
      end
    end
  end

  // Read slot walks the list during emission.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_row) begin
      read_slot <= '0;
    end else if (cmd.read_next) begin
      read_slot <= read_slot + SlotW'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      best_value  <= kept_values[read_slot];
      best_index  <= kept_indices[read_slot];
      last_of_row <= stat.read_last;
    end
  end

  always_comb begin
    stat.out_busy  = out_valid && !out_take;
    stat.read_last = (CntW'(read_slot) + CntW'(1) >= n_emit);
  end

  // The fill count never exceeds the list depth.
  assert property (@(posedge clk) disable iff (rst) kept_count <= CntW'(K_MAX))
    else $error("kept count above depth");
  // A result is only loaded when the output register is free.
  assert property (@(posedge clk) disable iff (rst) cmd.load_out |-> !stat.out_busy)
    else $error("output register overwritten");
  // A new row starts with an empty list.
  assert property (@(posedge clk) disable iff (rst) cmd.clear_row |=> kept_count == '0)
    else $error("list not cleared");

endmodule : rtks_datapath
`default_nettype wire

/* src/rtks_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Row top-k select controller
// Accepts elements, and on a row end walks the kept list into the output
// register one pair per transfer.
// ----------------------------------------------------------------------------
module rtks_ctrl (
  input  wire                       clk,
  input  wire                       rst,
  input  wire logic                 in_valid,
  input  wire logic                 row_end,
  output logic                      in_stall,
  input  wire rtks_pkg::rtks_stat_t stat,
  output rtks_pkg::rtks_cmd_t       cmd
);
  import rtks_pkg::*;

  localparam logic [1:0] StAccept = 2'd0;
  localparam logic [1:0] StEmit   = 2'd1;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       in_take;

  always_comb begin
    in_stall   = (state != StAccept);
    in_take    = in_valid && !in_stall;
    cmd        = '0;
    state_next = state;
    unique case (state)
      StAccept: begin
        cmd.insert = in_take;
        if (in_take && row_end) begin
          state_next = StEmit;
        end
      end
      StEmit: begin
        // Emptiness is impossible: the row end element itself was inserted.
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          if (stat.read_last) begin
            cmd.clear_row = 1'b1;
            state_next    = StAccept;
          end else begin
            cmd.read_next = 1'b1;
          end
        end
      end
      default: begin
        state_next = StAccept;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StAccept;
    end else begin
      state <= state_next;
    end
  end

  // Elements are only taken while not emitting.
  assert property (@(posedge clk) disable iff (rst) cmd.insert |-> state == StAccept)
    else $error("insert during emission");
  // A row end always leads to emission.
  assert property (@(posedge clk) disable iff (rst) (cmd.insert && row_end) |=> state == StEmit)
    else $error("row end not emitted");
  // Clearing ends the emission.
  assert property (@(posedge clk) disable iff (rst) cmd.clear_row |=> state == StAccept)
    else $error("clear without return");

endmodule : rtks_ctrl
`default_nettype wire

/* src/row_top_k_select.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Row top-k select
// Keeps the best k float32 elements of a row and emits them best first.
// ----------------------------------------------------------------------------
// Throughput: one element per cycle while a row streams in; the insertion
// chain compares against all kept entries at once.
// At a row end the block emits min(max(k, 1), K_MAX, row length) pairs, one per cycle
// when the output is not stalled, and takes no element until the last is loaded.
// First pair: loaded from the emit state once the output register is free.
// Reset: synchronous; clears the fill count, position, state and output valid.
module row_top_k_select #(
  parameter int K_MAX   = rtks_pkg::KMaxDefault,
  parameter int ROW_MAX = rtks_pkg::RowMaxDefault
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_we,
  input  wire  [4:0]  cfg_index,
  input  wire  [4:0]  cfg_data,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [31:0] elem_value,
  input  wire         row_end,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [31:0] best_value,
  output logic [15:0] best_index,
  output logic        last_of_row
);
  import rtks_pkg::*;

  logic [4:0] k_count;
  logic       pick_largest;
  rtks_cmd_t  cmd;
  rtks_stat_t stat;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      k_count      <= 5'd1;
      pick_largest <= 1'b1;
    end else if (cfg_we) begin
      if (cfg_index == RegKCount) begin
        k_count <= cfg_data;
      end else if (cfg_index == RegPickLargest) begin
        pick_largest <= cfg_data[0];
      end
    end
  end

  rtks_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .row_end  (row_end),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  rtks_datapath #(
    .K_MAX   (K_MAX),
    .ROW_MAX (ROW_MAX)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .elem_value   (elem_value),
    .k_count      (k_count),
    .pick_largest (pick_largest),
    .out_take     (out_valid && !out_stall),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (out_valid),
    .best_value   (best_value),
    .best_index   (best_index),
    .last_of_row  (last_of_row)
  );

endmodule : row_top_k_select
`default_nettype wire
